// File: rtl/plpcd_pkg.sv
// Shared types and constants of the pinned LRU page cache directory.
package plpcd_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int CFG_W      = 5;
    localparam int PAGE_W     = 32;
    localparam int STAMP_BITS = 32;
    localparam int PIN_W      = 8;

    localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

    localparam logic CMD_GET     = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        STAT_HIT  = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2,
        STAT_REL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_HIT,
        UPD_FILL,
        UPD_REL
    } upd_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // Search record that walks down the row of slot cells.
    typedef struct packed {
        logic                  valid;
        logic [SLOT_W-1:0]     idx;
        logic [PAGE_W-1:0]     key;
        logic                  hit;
        logic [SLOT_W-1:0]     hit_idx;
        logic                  inv_found;
        logic                  vic_found;
        logic [SLOT_W-1:0]     vic_idx;
        logic [STAMP_BITS-1:0] vic_stamp;
        logic                  vic_valid;
        logic [PAGE_W-1:0]     vic_page;
    } token_t;

    // Update broadcast to the cells; each cell has its own select line.
    typedef struct packed {
        upd_op_t               op;
        logic [PAGE_W-1:0]     page;
        logic [STAMP_BITS-1:0] stamp;
    } upd_t;

endpackage

// File: rtl/plpcd_cell.sv
// One directory slot: its entry state and its step of the search chain.
module plpcd_cell
    import plpcd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] n,
    input  token_t           tok_in,
    output token_t           tok_out,
    input  upd_t             upd,
    input  logic             sel
);

    logic                  valid_reg, valid_next;
    logic [PIN_W-1:0]      pins_reg, pins_next;
    logic [PAGE_W-1:0]     page_reg, page_next;
    logic [STAMP_BITS-1:0] stamp_reg, stamp_next;
    token_t                tok_reg, tok_next;
    logic                  in_range;

    always_comb begin
        in_range = {1'b0, tok_in.idx} < n;
        tok_next = tok_in;
        tok_next.idx = tok_in.idx + 1'b1;
        if (in_range && valid_reg && page_reg == tok_in.key && !tok_in.hit) begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = tok_in.idx;
        end
        // The first empty slot ends the victim search; until then the oldest
        // unpinned slot wins, later slots taking ties.
        if (in_range && !tok_in.inv_found) begin
            if (!valid_reg) begin
                tok_next.inv_found = 1'b1;
                tok_next.vic_found = 1'b1;
                tok_next.vic_idx   = tok_in.idx;
                tok_next.vic_valid = 1'b0;
            end else if (pins_reg == '0 &&
                         (!tok_in.vic_found || stamp_reg <= tok_in.vic_stamp)) begin
                tok_next.vic_found = 1'b1;
                tok_next.vic_idx   = tok_in.idx;
                tok_next.vic_stamp = stamp_reg;
                tok_next.vic_valid = 1'b1;
                tok_next.vic_page  = page_reg;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        pins_next  = pins_reg;
        page_next  = page_reg;
        stamp_next = stamp_reg;
        if (sel) begin
            case (upd.op)
                UPD_HIT: begin
                    stamp_next = upd.stamp;
                    if (pins_reg != PIN_MAX) begin
                        pins_next = pins_reg + 1'b1;
                    end
                end
                UPD_FILL: begin
                    valid_next = 1'b1;
                    page_next  = upd.page;
                    stamp_next = upd.stamp;
                    pins_next  = PIN_W'(1);
                end
                UPD_REL: begin
                    if (pins_reg != '0) begin
                        pins_next = pins_reg - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            pins_reg      <= '0;
            tok_reg.valid <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pins_reg  <= pins_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg  <= page_next;
        stamp_reg <= stamp_next;
    end

    assign tok_out = tok_reg;

endmodule

// File: rtl/pinned_lru_page_cache_directory.sv
// Top level of the pinned LRU page cache directory: control, counter and cell row.
// A get request is sent down a row of SLOTS cells, one cell per cycle; each cell
// checks its own slot for a match and for a better victim and passes the running
// record on. The last cell's record is captured in fin_reg; then, once the output
// is free, the slot update is committed and the result register loaded together.
// A release needs no search: it goes straight to that step, where its slot update
// is committed and its result loaded. The result is loaded only once the previous
// result has been transferred. One request is in flight at a time; the next
// request is taken as soon as the previous result has been loaded, even if it is
// not yet transferred. There is no clearing pass after reset.
module pinned_lru_page_cache_directory
    import plpcd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [PAGE_W-1:0] s_page_number,
    input  logic [3:0]        s_release_slot,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [3:0]        m_slot,
    output logic              m_evicted_valid,
    output logic [PAGE_W-1:0] m_evicted_page
);

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      slots_reg;
    logic [CNT_W-1:0]      n_sat;
    logic [STAMP_BITS-1:0] use_counter_reg, use_counter_next;
    logic                  cmd_reg, cmd_next;
    logic [SLOT_W-1:0]     rel_reg, rel_next;
    token_t                fin_reg, fin_next;
    logic                  m_valid_reg, m_valid_next;
    status_t               status_reg, status_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [PAGE_W-1:0]     ev_page_reg, ev_page_next;
    token_t                tok [SLOTS+1];
    logic [SLOTS-1:0]      tok_live;
    upd_t                  upd;
    logic [SLOT_W-1:0]     upd_slot;
    logic [SLOTS-1:0]      upd_sel;
    logic                  accept;

    assign n_sat = (slots_reg > CFG_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(slots_reg);
    assign accept = s_valid && s_ready;

    always_comb begin
        tok[0]       = '0;
        tok[0].valid = accept && s_cmd == CMD_GET;
        tok[0].key   = s_page_number;
    end

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        plpcd_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .n       (n_sat),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .upd     (upd),
            .sel     (upd_sel[i])
        );
        assign tok_live[i] = tok[i+1].valid;
    end

    always_comb begin
        state_next       = state_reg;
        use_counter_next = use_counter_reg;
        cmd_next         = cmd_reg;
        rel_next         = rel_reg;
        fin_next         = fin_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        status_next      = status_reg;
        slot_next        = slot_reg;
        ev_valid_next    = ev_valid_reg;
        ev_page_next     = ev_page_reg;
        upd.op           = UPD_NONE;
        upd.page         = fin_reg.key;
        upd.stamp        = use_counter_reg;
        upd_slot         = '0;
        s_ready          = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    cmd_next   = s_cmd;
                    rel_next   = SLOT_W'(s_release_slot);
                    state_next = (s_cmd == CMD_GET) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (tok[SLOTS].valid) begin
                    fin_next   = tok[SLOTS];
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    ev_valid_next = 1'b0;
                    ev_page_next  = '0;
                    state_next    = S_IDLE;
                    if (cmd_reg == CMD_RELEASE) begin
                        status_next = STAT_REL;
                        slot_next   = rel_reg;
                        upd.op      = UPD_REL;
                        upd_slot    = rel_reg;
                    end else if (fin_reg.hit) begin
                        status_next      = STAT_HIT;
                        slot_next        = fin_reg.hit_idx;
                        upd.op           = UPD_HIT;
                        upd_slot         = fin_reg.hit_idx;
                        use_counter_next = use_counter_reg + 1'b1;
                    end else if (fin_reg.vic_found) begin
                        status_next      = STAT_MISS;
                        slot_next        = fin_reg.vic_idx;
                        ev_valid_next    = fin_reg.vic_valid;
                        ev_page_next     = fin_reg.vic_valid ? fin_reg.vic_page : '0;
                        upd.op           = UPD_FILL;
                        upd_slot         = fin_reg.vic_idx;
                        use_counter_next = use_counter_reg + 1'b1;
                    end else begin
                        status_next = STAT_FULL;
                        slot_next   = '0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign upd_sel = (upd.op == UPD_NONE) ? '0 : (SLOTS'(1) << upd_slot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            slots_reg       <= CFG_W'(SLOTS);
            use_counter_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            use_counter_reg <= use_counter_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                slots_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        rel_reg      <= rel_next;
        fin_reg      <= fin_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        ev_valid_reg <= ev_valid_next;
        ev_page_reg  <= ev_page_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_slot          = 4'(slot_reg);
    assign m_evicted_valid = ev_valid_reg;
    assign m_evicted_page  = ev_page_reg;

`ifndef ASSERT_OFF
    // Only one search record may travel down the row at any time.
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_live))
        else $error("more than one search record in the cell row");

    // An update reaches exactly one cell.
    a_one_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        upd.op != UPD_NONE |-> $onehot(upd_sel))
        else $error("slot update does not select exactly one cell");

    // The use counter moves only when a slot is stamped.
    a_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        !(upd.op == UPD_HIT || upd.op == UPD_FILL) |=>
            use_counter_reg == $past(use_counter_reg))
        else $error("use counter advanced without a stamp");

    // No request is taken while a search is still in the row.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_live != '0 |-> !s_ready)
        else $error("request taken during a search");
`endif

endmodule
